>>> sv/bid_pkg.sv
`timescale 1ns / 1ps

package bid_pkg;

    localparam int unsigned BANK_W  = 32;
    localparam int unsigned PAD_W   = 96;

    localparam logic [1:0]  BANK_LO    = 2'd0;
    localparam logic [1:0]  BANK_MID   = 2'd1;
    localparam logic [1:0]  BANK_BASIC = 2'd2;
    localparam logic [1:0]  BANK_BAD   = 2'd3;
    localparam logic [31:0] BASIC_MASK = 32'h0000_00FF;

    typedef enum logic [1:0] {
        OP_REG = 2'd0,
        OP_EN  = 2'd1,
        OP_DIS = 2'd2,
        OP_SVC = 2'd3
    } t_op;

    typedef struct packed {
        t_op          op;
        logic [6:0]   irq;
        logic         err;
        logic [1:0]   bank;
        logic [31:0]  word;
    } t_cmd;

    function automatic logic [4:0] hi_bit(input logic [31:0] bits);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (bits[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

>>> sv/bid_front.sv
`timescale 1ns / 1ps

module bid_front #(
    parameter int NUM_IRQS = 72
) (
    input  logic [1:0]     i_opcode,
    input  logic [6:0]     i_irq_number,
    input  logic           i_handler_given,
    input  logic [1:0]     i_bank_select,
    input  logic           i_bank_flag,
    input  logic [31:0]    i_pending_word,
    output bid_pkg::t_cmd  o_cmd
);

    logic [31:0] word;
    logic        range_err;

    assign range_err = ({25'd0, i_irq_number} >= 32'(NUM_IRQS));

    always_comb begin
        word = i_bank_flag ? i_pending_word : 32'd0;
        if (i_bank_select == bid_pkg::BANK_BASIC) begin
            word = word & bid_pkg::BASIC_MASK;
        end
        o_cmd.op   = bid_pkg::t_op'(i_opcode);
        o_cmd.irq  = i_irq_number;
        o_cmd.bank = i_bank_select;
        o_cmd.word = word;
        unique case (bid_pkg::t_op'(i_opcode))
            bid_pkg::OP_REG:                 o_cmd.err = range_err | ~i_handler_given;
            bid_pkg::OP_EN, bid_pkg::OP_DIS: o_cmd.err = range_err;
            bid_pkg::OP_SVC:                 o_cmd.err = (i_bank_select == bid_pkg::BANK_BAD);
            default:                         o_cmd.err = 1'b1;
        endcase
    end

endmodule

>>> sv/bid_queue.sv
`timescale 1ns / 1ps

module bid_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bid_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output bid_pkg::t_cmd  o_cmd
);

    bid_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          n_wr_ptr;
    logic          n_rd_ptr;
    logic [1:0]    n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> sv/bid_back.sv
`timescale 1ns / 1ps

module bid_back #(
    parameter int NUM_IRQS = 72
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  bid_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    output logic           o_strobe,
    output logic           o_dispatch,
    output logic [6:0]     o_irq_id,
    output logic           o_status,
    output logic           o_last
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state                r_state;
    logic [NUM_IRQS-1:0]   r_en;
    logic [NUM_IRQS-1:0]   r_hd;
    logic [31:0]           r_bits;
    logic [1:0]            r_bank;
    logic                  r_strobe;
    logic                  r_dispatch;
    logic [6:0]            r_irq_id;
    logic                  r_status;
    logic                  r_last;

    logic [bid_pkg::PAD_W-1:0] en_pad;
    logic [bid_pkg::PAD_W-1:0] hd_pad;
    logic [31:0]               en_slice;
    logic [31:0]               hd_slice;
    logic [31:0]               eligible;
    logic [4:0]                pos;
    logic [31:0]               rest;

    for (genvar g = 0; g < bid_pkg::PAD_W; g++) begin : g_pad
        if (g < NUM_IRQS) begin : g_live
            assign en_pad[g] = r_en[g];
            assign hd_pad[g] = r_hd[g];
        end else begin : g_zero
            assign en_pad[g] = 1'b0;
            assign hd_pad[g] = 1'b0;
        end
    end

    always_comb begin
        unique case (i_cmd.bank)
            bid_pkg::BANK_LO: begin
                en_slice = en_pad[31:0];
                hd_slice = hd_pad[31:0];
            end
            bid_pkg::BANK_MID: begin
                en_slice = en_pad[63:32];
                hd_slice = hd_pad[63:32];
            end
            bid_pkg::BANK_BASIC: begin
                en_slice = en_pad[95:64];
                hd_slice = hd_pad[95:64];
            end
            default: begin
                en_slice = 32'd0;
                hd_slice = 32'd0;
            end
        endcase
        eligible = i_cmd.word & en_slice & hd_slice;
        pos      = bid_pkg::hi_bit(r_bits);
        rest     = r_bits & ~(32'd1 << pos);
    end

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign o_strobe   = r_strobe;
    assign o_dispatch = r_dispatch;
    assign o_irq_id   = r_irq_id;
    assign o_status   = r_status;
    assign o_last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_en       <= '0;
            r_hd       <= '0;
            r_strobe   <= 1'b0;
            r_bits     <= 32'd0;
            r_bank     <= 2'd0;
            r_dispatch <= 1'b0;
            r_irq_id   <= 7'd0;
            r_status   <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        if (i_cmd.op != bid_pkg::OP_SVC) begin
                            if (!i_cmd.err) begin
                                for (int i = 0; i < NUM_IRQS; i++) begin
                                    if (i_cmd.irq == 7'(i)) begin
                                        if (i_cmd.op == bid_pkg::OP_REG) begin
                                            r_hd[i] <= 1'b1;
                                        end else begin
                                            r_en[i] <= (i_cmd.op == bid_pkg::OP_EN);
                                        end
                                    end
                                end
                            end
                            r_strobe   <= 1'b1;
                            r_dispatch <= 1'b0;
                            r_irq_id   <= i_cmd.irq;
                            r_status   <= i_cmd.err;
                            r_last     <= 1'b1;
                        end else if (i_cmd.err || eligible == 32'd0) begin
                            r_strobe   <= 1'b1;
                            r_dispatch <= 1'b0;
                            r_irq_id   <= 7'd0;
                            r_status   <= i_cmd.err;
                            r_last     <= 1'b1;
                        end else begin
                            r_bits  <= eligible;
                            r_bank  <= i_cmd.bank;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    r_strobe   <= 1'b1;
                    r_dispatch <= 1'b1;
                    r_irq_id   <= {r_bank, pos};
                    r_status   <= 1'b0;
                    r_last     <= (rest == 32'd0);
                    r_bits     <= rest;
                    if (rest == 32'd0) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/banked_interrupt_dispatcher.sv
`timescale 1ns / 1ps
// Register/enable/disable/bad-bank items: the item is written to the queue, then the back end
// registers its single result. Service items: the back end loads the eligible pending bits,
// then walks them, one dispatch per cycle, highest IRQ first, until the last one is sent.
// The walk clears one pending bit per cycle; a 2-entry queue decouples it from new items.
// Results cannot be stalled by the receiver. Reset (synchronous) clears enables, handlers, queue.
module banked_interrupt_dispatcher #(
    parameter int NUM_IRQS = 72
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [6:0]  i_irq_number,
    input  logic        i_handler_given,
    input  logic [1:0]  i_bank_select,
    input  logic        i_bank_flag,
    input  logic [31:0] i_pending_word,
    output logic        o_strobe,
    output logic        o_dispatch,
    output logic [6:0]  o_irq_id,
    output logic        o_status,
    output logic        o_last
);

    bid_pkg::t_cmd front_cmd;
    bid_pkg::t_cmd head_cmd;
    logic          q_full;
    logic          q_empty;
    logic          pop;

    assign busy = q_full;

    bid_front #(.NUM_IRQS(NUM_IRQS)) u_front (
        .i_opcode        (i_opcode),
        .i_irq_number    (i_irq_number),
        .i_handler_given (i_handler_given),
        .i_bank_select   (i_bank_select),
        .i_bank_flag     (i_bank_flag),
        .i_pending_word  (i_pending_word),
        .o_cmd           (front_cmd)
    );

    bid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !q_full),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    bid_back #(.NUM_IRQS(NUM_IRQS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_strobe   (o_strobe),
        .o_dispatch (o_dispatch),
        .o_irq_id   (o_irq_id),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

>>> sv/bid_checker.sv
`timescale 1ns / 1ps

module bid_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_strobe,
    input logic       o_dispatch,
    input logic [6:0] o_irq_id,
    input logic       o_status,
    input logic       o_last
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result strobe after reset");

    a_dispatch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_dispatch |-> !o_status)
        else $error("dispatch with error status");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_dispatch |-> o_last)
        else $error("non-dispatch item not last");

    a_walk_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_dispatch && !o_last |=> o_strobe && o_dispatch)
        else $error("dispatch list broken");

    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_dispatch && !o_last |=> o_irq_id < $past(o_irq_id))
        else $error("dispatch order not descending");

endmodule

bind banked_interrupt_dispatcher bid_checker u_bid_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_strobe   (o_strobe),
    .o_dispatch (o_dispatch),
    .o_irq_id   (o_irq_id),
    .o_status   (o_status),
    .o_last     (o_last)
);
